// ----- src/sapd_pkg.sv -----
// ----------------------------------------------------------------------------
// sapd_pkg
// Shared types and constants for the prefix-doubling suffix array builder.
// ----------------------------------------------------------------------------
package sapd_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;
    localparam int CHAR_W      = 8;
    localparam int RANK_W      = 6;
    localparam int KEY_W       = 2 * RANK_W;
    localparam int MAX_CHARS_DEFAULT = 63;

    typedef struct packed {
        logic              load;
        logic [CHAR_W-1:0] ch;
        logic              clear;
        logic [ADDR_W-1:0] rd_addr;
        logic [LEN_W-1:0]  k;
        logic              first;
        logic              key_we;
        logic [ADDR_W-1:0] key_waddr;
        logic              keyi_load;
        logic              cnt_clr;
        logic              cnt_acc;
        logic              rank_we;
        logic [ADDR_W-1:0] rank_waddr;
        logic              ord_we;
        logic [ADDR_W-1:0] ord_wdata;
        logic              out_load;
        logic              out_last;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] n;
    } status_t;

endpackage

// ----- src/sapd_ram.sv -----
// ----------------------------------------------------------------------------
// sapd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sapd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/sapd_dp.sv -----
// ----------------------------------------------------------------------------
// sapd_dp
// Datapath: text, key, rank and order memories, rank counter, output register.
// ----------------------------------------------------------------------------
module sapd_dp #(
    parameter int MAX_CHARS = sapd_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sapd_pkg::cmd_t                cmd,
    output sapd_pkg::status_t             status,
    output logic [sapd_pkg::ADDR_W-1:0]   position,
    output logic                          last_position,
    output logic                          truncated
);

    localparam int AW = sapd_pkg::ADDR_W;
    localparam int LW = sapd_pkg::LEN_W;
    localparam int RW = sapd_pkg::RANK_W;
    localparam int KW = sapd_pkg::KEY_W;
    localparam int CW = sapd_pkg::CHAR_W;
    localparam int SD = sapd_pkg::STORE_DEPTH;

    logic [LW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [KW-1:0] keyi_reg;
    logic [RW-1:0] cnt_reg;
    logic [AW-1:0] pos_reg;
    logic          last_reg;

    logic [CW-1:0] text_rd;
    logic [RW-1:0] rank_a_rd, rank_b_rd;
    logic [KW-1:0] key_rd, key_wdata;
    logic [AW-1:0] ord_rd, rb_addr;
    logic [LW-1:0] n;
    logic [LW:0]   sum, sum_mod;
    logic          text_we;

    assign n       = len_reg + LW'(1);
    assign text_we = cmd.load && (len_reg < LW'(MAX_CHARS));
    assign sum     = {2'b00, cmd.rd_addr} + {1'b0, cmd.k};
    assign sum_mod = (sum >= {1'b0, n}) ? (sum - {1'b0, n}) : sum;
    assign rb_addr = sum_mod[AW-1:0];

    always_comb
    begin
        if (cmd.first)
        begin
            if ({1'b0, cmd.key_waddr} == n - LW'(1))
            begin
                key_wdata = '0;
            end
            else
            begin
                key_wdata = KW'({1'b0, text_rd} + 9'd1);
            end
        end
        else
        begin
            key_wdata = {rank_a_rd, rank_b_rd};
        end
    end

    always_comb
    begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (cmd.clear)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.load)
        begin
            if (text_we)
            begin
                len_next = len_reg + LW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.keyi_load)
        begin
            keyi_reg <= key_rd;
        end
        if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_acc && (key_rd < keyi_reg))
        begin
            cnt_reg <= cnt_reg + RW'(1);
        end
        if (cmd.out_load)
        begin
            pos_reg  <= ord_rd;
            last_reg <= cmd.out_last;
        end
    end

    sapd_ram #(.WIDTH(CW), .DEPTH(SD)) u_text (
        .clk(clk), .we(text_we), .waddr(len_reg[AW-1:0]), .wdata(cmd.ch),
        .raddr(cmd.rd_addr), .rdata(text_rd)
    );

    sapd_ram #(.WIDTH(KW), .DEPTH(SD)) u_key (
        .clk(clk), .we(cmd.key_we), .waddr(cmd.key_waddr), .wdata(key_wdata),
        .raddr(cmd.rd_addr), .rdata(key_rd)
    );

    sapd_ram #(.WIDTH(RW), .DEPTH(SD)) u_rank_a (
        .clk(clk), .we(cmd.rank_we), .waddr(cmd.rank_waddr), .wdata(cnt_reg),
        .raddr(cmd.rd_addr), .rdata(rank_a_rd)
    );

    sapd_ram #(.WIDTH(RW), .DEPTH(SD)) u_rank_b (
        .clk(clk), .we(cmd.rank_we), .waddr(cmd.rank_waddr), .wdata(cnt_reg),
        .raddr(rb_addr), .rdata(rank_b_rd)
    );

    sapd_ram #(.WIDTH(AW), .DEPTH(SD)) u_order (
        .clk(clk), .we(cmd.ord_we), .waddr(rank_a_rd), .wdata(cmd.ord_wdata),
        .raddr(cmd.rd_addr), .rdata(ord_rd)
    );

    assign status.n      = n;
    assign position      = pos_reg;
    assign last_position = last_reg;
    assign truncated     = ovf_reg;

endmodule

// ----- src/sapd_ctrl.sv -----
// ----------------------------------------------------------------------------
// sapd_ctrl
// Controller: sequences loading, key building, rank counting, order building and readout.
// ----------------------------------------------------------------------------
module sapd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sapd_pkg::CHAR_W-1:0]   ch,
    input  logic                          end_of_text,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  sapd_pkg::status_t             status,
    output sapd_pkg::cmd_t                cmd
);

    localparam int AW = sapd_pkg::ADDR_W;
    localparam int LW = sapd_pkg::LEN_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_KB   = 9'b000000010,
        S_CI   = 9'b000000100,
        S_CL   = 9'b000001000,
        S_CS   = 9'b000010000,
        S_OW   = 9'b000100000,
        S_OR1  = 9'b001000000,
        S_OR2  = 9'b010000000,
        S_OR3  = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [LW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic          first_reg, first_next, vd_reg, vd_next;
    logic [AW-1:0] id_reg, id_next;
    logic [LW-1:0] n;

    assign n = status.n;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        first_next = first_reg;
        vd_next    = 1'b0;
        id_next    = id_reg;
        cmd        = '0;
        cmd.ch     = ch;
        cmd.k      = k_reg;
        cmd.first  = first_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (end_of_text)
                    begin
                        state_next = S_KB;
                        i_next     = '0;
                        k_next     = '0;
                        first_next = 1'b1;
                    end
                end
            end
            S_KB:
            begin
                cmd.rd_addr   = i_reg[AW-1:0];
                cmd.key_we    = vd_reg;
                cmd.key_waddr = id_reg;
                if (i_reg < n)
                begin
                    vd_next = 1'b1;
                    id_next = i_reg[AW-1:0];
                    i_next  = i_reg + LW'(1);
                end
                else if (!vd_reg)
                begin
                    state_next = S_CI;
                    i_next     = '0;
                end
            end
            S_CI:
            begin
                cmd.rd_addr = i_reg[AW-1:0];
                state_next  = S_CL;
            end
            S_CL:
            begin
                cmd.keyi_load = 1'b1;
                cmd.cnt_clr   = 1'b1;
                j_next        = '0;
                state_next    = S_CS;
            end
            S_CS:
            begin
                cmd.rd_addr = j_reg[AW-1:0];
                cmd.cnt_acc = vd_reg;
                if (j_reg < n)
                begin
                    vd_next = 1'b1;
                    j_next  = j_reg + LW'(1);
                end
                else if (!vd_reg)
                begin
                    cmd.rank_we    = 1'b1;
                    cmd.rank_waddr = i_reg[AW-1:0];
                    if (i_reg + LW'(1) < n)
                    begin
                        i_next     = i_reg + LW'(1);
                        state_next = S_CI;
                    end
                    else
                    begin
                        i_next = '0;
                        if (first_reg)
                        begin
                            first_next = 1'b0;
                            k_next     = LW'(1);
                            state_next = S_KB;
                        end
                        else if ({k_reg, 1'b0} >= {1'b0, n})
                        begin
                            state_next = S_OW;
                        end
                        else
                        begin
                            k_next     = {k_reg[LW-2:0], 1'b0};
                            state_next = S_KB;
                        end
                    end
                end
            end
            S_OW:
            begin
                cmd.rd_addr   = i_reg[AW-1:0];
                cmd.ord_we    = vd_reg;
                cmd.ord_wdata = id_reg;
                if (i_reg < n)
                begin
                    vd_next = 1'b1;
                    id_next = i_reg[AW-1:0];
                    i_next  = i_reg + LW'(1);
                end
                else if (!vd_reg)
                begin
                    state_next = S_OR1;
                    i_next     = '0;
                end
            end
            S_OR1:
            begin
                cmd.rd_addr = i_reg[AW-1:0];
                state_next  = S_OR2;
            end
            S_OR2:
            begin
                cmd.out_load = 1'b1;
                cmd.out_last = (i_reg + LW'(1) == n);
                state_next   = S_OR3;
            end
            S_OR3:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (i_reg + LW'(1) == n)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + LW'(1);
                        state_next = S_OR1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            first_reg <= 1'b0;
            vd_reg    <= 1'b0;
            id_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            first_reg <= first_next;
            vd_reg    <= vd_next;
            id_reg    <= id_next;
        end
    end

endmodule

// ----- src/suffix_array_prefix_doubling.sv -----
// Sequence: after the closing character, each round builds the keys and then counts
// ranks for every position; once the rounds are done the order table is built and
// the results are read out one at a time.
// Throughput: one text at a time; characters are taken one per cycle while loading.
// Reset: asynchronous, active low; clears length, overflow flag and control state.
// ----------------------------------------------------------------------------
// suffix_array_prefix_doubling
// Builds the suffix array of a byte string plus sentinel by prefix doubling.
// ----------------------------------------------------------------------------
module suffix_array_prefix_doubling #(
    parameter int MAX_CHARS = sapd_pkg::MAX_CHARS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [5:0] position, [7:6] zero
    output logic       m_tlast,   // last_position
    output logic       m_tuser    // [0] truncated
);

    sapd_pkg::cmd_t    cmd;
    sapd_pkg::status_t status;
    logic [sapd_pkg::ADDR_W-1:0] position;

    sapd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .ch(s_tdata), .end_of_text(s_tlast),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .status(status), .cmd(cmd)
    );

    sapd_dp #(.MAX_CHARS(MAX_CHARS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .position(position), .last_position(m_tlast), .truncated(m_tuser)
    );

    assign m_tdata = {2'b00, position};

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output active together");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("no return to loading after final result");

    a_next_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid)
        else $error("result repeated without new read");

endmodule

// ----- verif/suffix_array_prefix_doubling_tb.sv -----
// ----------------------------------------------------------------------------
// suffix_array_prefix_doubling_tb
// Streams byte texts into the suffix array builder with random gaps on both
// sides and checks every emitted position, last mark and truncation flag
// against a predicted suffix array of the cyclic text plus sentinel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class sa_scoreboard;
    typedef struct {
        logic [5:0] position;
        logic       last_position;
        logic       truncated;
    } sa_entry_t;

    sa_entry_t  pending[$];
    logic [7:0] text[64];
    int         text_len;
    bit         dropped;
    int         errors;

    function new();
        text_len = 0;
        dropped  = 0;
        errors   = 0;
    endfunction

    // Rotation a sorts below rotation b; the sentinel key is zero.
    function bit rot_less(int key[64], int n, int a, int b);
        int t;
        for (t = 0; t < n; t++)
        begin
            if (key[(a + t) % n] != key[(b + t) % n])
                return key[(a + t) % n] < key[(b + t) % n];
        end
        return 0;
    endfunction

    function void note_char(logic [7:0] ch, logic eot);
        int        key[64];
        int        ord[64];
        int        n;
        int        i;
        int        j;
        int        cur;
        sa_entry_t e;
        if (text_len < 63)
        begin
            text[text_len] = ch;
            text_len++;
        end
        else
            dropped = 1;
        if (!eot)
            return;
        n = text_len + 1;
        for (i = 0; i < n; i++)
        begin
            key[i] = (i < text_len) ? int'(text[i]) + 1 : 0;
            ord[i] = i;
        end
        for (i = 1; i < n; i++)
        begin
            cur = ord[i];
            j = i;
            while (j > 0 && rot_less(key, n, cur, ord[j - 1]))
            begin
                ord[j] = ord[j - 1];
                j--;
            end
            ord[j] = cur;
        end
        for (i = 0; i < n; i++)
        begin
            e.position      = ord[i][5:0];
            e.last_position = (i == n - 1);
            e.truncated     = dropped;
            pending.push_back(e);
        end
        text_len = 0;
        dropped  = 0;
    endfunction

    function void check_result(logic [7:0] data, logic last, logic user);
        sa_entry_t e;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected transfer: data=%h last=%b user=%b", data, last, user);
            return;
        end
        e = pending.pop_front();
        if (data !== {2'b00, e.position} || last !== e.last_position || user !== e.truncated)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected pos=%0d last=%b trunc=%b, got data=%h last=%b user=%b",
                         e.position, e.last_position, e.truncated, data, last, user);
        end
    endfunction
endclass

module suffix_array_prefix_doubling_tb;
    localparam int LIMIT = 3000000;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    sa_scoreboard sb = new();
    int cycle;
    int hold_cnt;
    int sent;

    suffix_array_prefix_doubling u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function bit calm();
        return cycle > 3000 && cycle < 12000;
    endfunction

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("suffix_array_prefix_doubling_tb: done, errors");
            $finish;
        end
    end

    // Result side: one long hold-off early on, random stalls outside the calm window.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
            if (cycle == 40)
                hold_cnt <= 1500;
            else if (hold_cnt > 0)
                hold_cnt <= hold_cnt - 1;
            if (hold_cnt > 1 || cycle == 40)
                m_tready <= 0;
            else
                m_tready <= calm() || ($urandom_range(99) >= 17);
        end
    end

    task automatic send_char(logic [7:0] ch, logic eot);
        if (!calm() && $urandom_range(99) < 17)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= ch;
        s_tlast  <= eot;
        do @(posedge clk); while (!s_tready);
        sb.note_char(ch, eot);
        sent++;
    endtask

    task automatic send_text(int len, int alpha);
        int i;
        for (i = 0; i < len; i++)
        begin
            if (alpha == 0)
                send_char(8'($urandom), i == len - 1);
            else
                send_char(8'($urandom_range(97, 96 + alpha)), i == len - 1);
        end
    endtask

    initial
    begin
        int len;
        cycle    = 0;
        hold_cnt = 0;
        sent     = 0;
        rst_n    = 0;
        s_tvalid = 0;
        s_tdata  = 0;
        s_tlast  = 0;
        m_tready = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_char(8'h00, 1);
        send_char(8'hff, 1);
        send_char(8'h00, 0);
        send_char(8'hff, 0);
        send_char(8'h00, 1);
        send_char(8'h61, 0);
        send_char(8'h61, 0);
        send_char(8'h61, 1);
        send_text(5, 2);
        // Fill the store with a full-length text, then send a short two-character text.
        send_text(63, 0);
        send_char(8'h55, 0);
        send_char(8'haa, 1);
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        while (sent < 110)
        begin
            case ($urandom_range(9))
                0:       len = $urandom_range(10, 20);
                1, 2:    len = 1;
                default: len = $urandom_range(2, 9);
            endcase
            send_text(len, ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 4));
        end
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("suffix_array_prefix_doubling_tb: done, clean");
        else
            $display("suffix_array_prefix_doubling_tb: done, errors");
        $finish;
    end
endmodule
